### sv/bt_pkg.sv
// Shared types and constants for the per-core busy time monitor.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
`default_nettype none

package bt_pkg;

    localparam logic [1:0] MODE_ACT    = 2'd0;
    localparam logic [1:0] MODE_IDLE   = 2'd1;
    localparam logic [1:0] MODE_OTHER  = 2'd2;
    localparam logic [1:0] MODE_REPORT = 2'd3;

    localparam int          PCT_W   = 15;
    localparam int          Q_STEPS = 15;
    localparam int          CNT_W   = 5;
    localparam logic [14:0] Q8_FULL = 15'd25600;
    localparam logic [4:0]  MAX_RES = 5'd16;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  core;
        logic [47:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  core_id;
        logic [14:0] percent;
        logic        zero_time;
        logic        last;
    } t_result;

    typedef struct packed {
        logic capture;
        logic rd_walk;
        logic event_go;
        logic chk;
        logic take_q;
        logic buf_load;
        logic emit;
        logic emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic need_div;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

### sv/bt_div.sv
// Iterative divider: floor(busy * 25600 / fin) for busy < fin, one quotient bit a cycle.
// Depends on bt_pkg.
`default_nettype none

module bt_div #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [TIME_BITS-1:0]      i_busy,
    input  wire logic [TIME_BITS-1:0]      i_fin,
    output logic                           o_done,
    output logic [bt_pkg::PCT_W-1:0]       o_quot
);

    localparam int NW = TIME_BITS + bt_pkg::Q_STEPS;

    logic [NW-1:0]                  num;
    logic [TIME_BITS:0]             trial;
    logic [TIME_BITS:0]             diff;
    logic                           ge;

    logic [TIME_BITS-1:0]           r_rem,  n_rem;
    logic [bt_pkg::Q_STEPS-1:0]     r_lo,   n_lo;
    logic [bt_pkg::PCT_W-1:0]       r_q,    n_q;
    logic [3:0]                     r_cnt,  n_cnt;
    logic                           r_run,  n_run;
    logic                           r_done, n_done;

    // busy * 25600 = (busy << 14) + (busy << 13) + (busy << 10)
    assign num = (NW'(i_busy) << 14) + (NW'(i_busy) << 13) + (NW'(i_busy) << 10);

    assign trial = {r_rem, r_lo[bt_pkg::Q_STEPS-1]};
    assign diff  = trial - {1'b0, i_fin};
    assign ge    = (trial >= {1'b0, i_fin});

    always_comb begin
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = num[NW-1:bt_pkg::Q_STEPS];
            n_lo  = num[bt_pkg::Q_STEPS-1:0];
            n_q   = '0;
            n_cnt = 4'(bt_pkg::Q_STEPS);
            n_run = 1'b1;
        end else if (r_run) begin
            n_rem = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            n_lo  = {r_lo[bt_pkg::Q_STEPS-2:0], 1'b0};
            n_q   = {r_q[bt_pkg::PCT_W-2:0], ge};
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

### sv/bt_dp.sv
// Datapath: per-core flags, start and busy time memories, final time, result buffer.
// Depends on bt_pkg and bt_div.
`default_nettype none

module bt_dp #(
    parameter int NUM_CORES = 16,
    parameter int TIME_BITS = 48,
    parameter int IW        = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bt_pkg::t_in_item   i_item,
    input  wire bt_pkg::t_dp_cmd    i_cmd,
    input  wire logic [IW-1:0]      i_idx,
    output bt_pkg::t_dp_sts         o_sts,
    output logic                    o_strobe,
    output bt_pkg::t_result         o_result
);

    localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIME_BITS-1:0] start_mem [NUM_CORES];
    logic [TIME_BITS-1:0] busy_mem  [NUM_CORES];

    logic [NUM_CORES-1:0]      r_active;
    logic [NUM_CORES-1:0]      r_has_busy;
    logic [TIME_BITS-1:0]      r_final;
    logic [TIME_BITS-1:0]      r_ts;
    logic [1:0]                r_mode;
    logic [CW-1:0]             r_core;
    logic                      r_in_range;
    logic [TIME_BITS-1:0]      r_start_rd;
    logic [TIME_BITS-1:0]      r_busy_rd;
    logic [bt_pkg::PCT_W-1:0]  r_pct;
    logic                      r_zt;
    logic [3:0]                r_buf_id;
    logic [bt_pkg::PCT_W-1:0]  r_buf_pct;
    logic                      r_buf_zt;
    logic                      r_strobe;
    bt_pkg::t_result           r_out;

    logic [CW-1:0]             rd_addr;
    logic                      cur_active;
    logic                      cur_has_busy;
    logic                      do_act;
    logic                      do_idle;
    logic [TIME_BITS-1:0]      iv;
    logic [TIME_BITS-1:0]      sum_in;
    logic [TIME_BITS:0]        sum_raw;
    logic [TIME_BITS-1:0]      sum_sat;
    logic                      fin_zero;
    logic                      busy_ge;
    logic                      div_done;
    logic [bt_pkg::PCT_W-1:0]  div_q;

    assign rd_addr      = i_cmd.rd_walk ? i_idx[CW-1:0] : CW'(i_item.core);
    assign cur_active   = r_in_range && r_active[r_core];
    assign cur_has_busy = r_in_range && r_has_busy[r_core];
    assign do_act       = i_cmd.event_go && (r_mode == bt_pkg::MODE_ACT) && r_in_range
                          && !cur_active;
    assign do_idle      = i_cmd.event_go && (r_mode == bt_pkg::MODE_IDLE) && cur_active;

    assign iv      = (r_ts > r_start_rd) ? (r_ts - r_start_rd) : '0;
    assign sum_in  = cur_has_busy ? r_busy_rd : '0;
    assign sum_raw = {1'b0, sum_in} + {1'b0, iv};
    assign sum_sat = sum_raw[TIME_BITS] ? TMAX : sum_raw[TIME_BITS-1:0];

    assign fin_zero = (r_final == '0);
    assign busy_ge  = (r_busy_rd >= r_final);

    always_ff @(posedge i_clk) begin
        r_start_rd <= start_mem[rd_addr];
        r_busy_rd  <= busy_mem[rd_addr];
        if (do_act) begin
            start_mem[r_core] <= r_ts;
        end
        if (do_idle) begin
            busy_mem[r_core] <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_has_busy <= '0;
            r_final    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.capture) begin
                r_final <= TIME_BITS'(i_item.timestamp);
            end
            if (do_act) begin
                r_active[r_core] <= 1'b1;
            end
            if (do_idle) begin
                r_active[r_core]   <= 1'b0;
                r_has_busy[r_core] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ts       <= TIME_BITS'(i_item.timestamp);
            r_mode     <= i_item.mode;
            r_core     <= CW'(i_item.core);
            r_in_range <= (32'(i_item.core) < NUM_CORES);
        end
        if (i_cmd.chk) begin
            r_zt  <= fin_zero;
            r_pct <= fin_zero ? '0 : bt_pkg::Q8_FULL;
        end
        if (i_cmd.take_q) begin
            r_pct <= div_q;
        end
        if (i_cmd.emit) begin
            r_out.core_id   <= r_buf_id;
            r_out.percent   <= r_buf_pct;
            r_out.zero_time <= r_buf_zt;
            r_out.last      <= i_cmd.emit_last;
        end
        if (i_cmd.buf_load) begin
            r_buf_id  <= 4'(i_idx);
            r_buf_pct <= r_pct;
            r_buf_zt  <= r_zt;
        end
    end

    bt_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.chk && !fin_zero && !busy_ge),
        .i_busy  (r_busy_rd),
        .i_fin   (r_final),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_sts.hit      = (32'(i_idx) < NUM_CORES) && r_has_busy[i_idx[CW-1:0]];
    assign o_sts.need_div = !fin_zero && !busy_ge;
    assign o_sts.div_done = div_done;
    assign o_strobe       = r_strobe;
    assign o_result       = r_out;

endmodule

`default_nettype wire

### sv/bt_ctrl.sv
// Controller: event sequencing and the report walk over the cores.
// Depends on bt_pkg; drives bt_dp through command and status structs.
`default_nettype none

module bt_ctrl #(
    parameter int NUM_CORES = 16,
    parameter int IW        = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_mode,
    input  wire bt_pkg::t_dp_sts   i_sts,
    output bt_pkg::t_dp_cmd        o_cmd,
    output logic [IW-1:0]          o_idx,
    output logic                   o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVENT = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    localparam logic [IW-1:0] IDX_END = IW'(NUM_CORES);

    logic [2:0]               r_state,    n_state;
    logic [IW-1:0]            r_idx,      n_idx;
    logic [IW-1:0]            r_rep,      n_rep;
    logic [bt_pkg::CNT_W-1:0] r_cnt,      n_cnt;
    logic                     r_have_buf, n_have_buf;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rep      = r_rep;
        n_cnt      = r_cnt;
        n_have_buf = r_have_buf;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_mode) inside
                        bt_pkg::MODE_ACT, bt_pkg::MODE_IDLE: begin
                            n_state = S_EVENT;
                        end
                        bt_pkg::MODE_REPORT: begin
                            n_state    = S_SCAN;
                            n_idx      = (r_rep < IDX_END) ? r_rep : '0;
                            n_cnt      = '0;
                            n_have_buf = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EVENT: begin
                o_cmd.event_go = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                if (r_idx == IDX_END) begin
                    o_cmd.emit      = r_have_buf;
                    o_cmd.emit_last = 1'b1;
                    n_rep           = '0;
                    n_state         = S_IDLE;
                end else if (i_sts.hit) begin
                    if (r_cnt == bt_pkg::MAX_RES) begin
                        o_cmd.emit = 1'b1;
                        n_rep      = r_idx;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.rd_walk = 1'b1;
                        n_state       = S_LOAD;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.need_div ? S_DIV : S_PUT;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.take_q = 1'b1;
                    n_state      = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.buf_load = 1'b1;
                o_cmd.emit     = r_have_buf;
                n_have_buf     = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                n_idx          = r_idx + 1'b1;
                n_state        = S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_rep      <= '0;
            r_cnt      <= '0;
            r_have_buf <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_rep      <= n_rep;
            r_cnt      <= n_cnt;
            r_have_buf <= n_have_buf;
        end
    end

    assign o_idx  = r_idx;
    assign o_busy = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_SCAN || r_state == S_PUT))
        else $error("result transfer outside scan or put");
    a_emit_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_have_buf)
        else $error("result transfer with empty buffer");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= bt_pkg::MAX_RES)
        else $error("report result count overrun");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_PUT))
        else $error("divide wait left wrongly");
    a_rep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep < IDX_END)
        else $error("report index out of range");
`endif

endmodule

`default_nettype wire

### sv/per_core_busy_time_monitor_unit.sv
// Per-core busy time monitor: top level joining controller and datapath.
// Depends on bt_pkg, bt_ctrl, bt_dp (and bt_div below it).
//
// An event is taken when start is high and busy is low. Activate and idle have an
// accept step, then a read-modify-write through the time memories' single read
// port; other events end at accept. A report has an accept step, a scan step per
// core passed over, a closing scan step, and per reported core scan, load and put
// steps, plus the 15-step divider unless the final time is zero or busy reaches it.
// Each result appears on o_result for one cycle with o_strobe high and cannot be
// held off; the last result of a report is there in the first cycle with busy low.
`default_nettype none

module per_core_busy_time_monitor_unit #(
    parameter int NUM_CORES = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bt_pkg::t_in_item  i_item,
    output logic                   o_strobe,
    output bt_pkg::t_result        o_result
);

    localparam int IW = $clog2(NUM_CORES + 1);

    bt_pkg::t_dp_cmd cmd;
    bt_pkg::t_dp_sts sts;
    logic [IW-1:0]   idx;

    bt_ctrl #(
        .NUM_CORES (NUM_CORES),
        .IW        (IW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idx   (idx),
        .o_busy  (busy)
    );

    bt_dp #(
        .NUM_CORES (NUM_CORES),
        .TIME_BITS (TIME_BITS),
        .IW        (IW)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .i_idx    (idx),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
